[design/vrt_pkg.sv]
package vrt_pkg;

  // Fixed-point format of distances, coordinates and the unit direction.
  localparam int FRAC_BITS = 16;
  localparam int VOXEL_BITS_DEF = 16;

  // Distances along the ray saturate at the top of this width.
  localparam int T_W = 48;
  localparam logic [T_W-1:0] T_MAX = '1;

  // Unit direction magnitude never exceeds 1.0.
  localparam int U_W = FRAC_BITS + 1;
  localparam logic [U_W-1:0] ONE_Q = U_W'(64'd1 << FRAC_BITS);
  localparam logic [U_W-1:0] EPS_UNIT = U_W'((64'd1 << FRAC_BITS) / 64'd1000000);

  // Smallest squared direction length that still counts as a direction.
  localparam logic [63:0] LEN_SQ_MIN =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000;

  // Shared restoring divider.
  localparam int DEN_W = 33;
  localparam int REM_W = DEN_W + 1;
  localparam int NUM_W = 2 * FRAC_BITS + 1;
  localparam int QUO_W = NUM_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

[design/voxel_ray_traversal_top.sv]
// Voxel ray walker (3D DDA). A start request (operation 0) carries a ray
// origin, an unnormalized direction and a maximum distance in Q16.16. The
// block normalizes the direction, derives per-axis step signs, per-voxel
// crossing distances and first boundary distances, and then emits a voxel
// query (kind 0) for the voxel that holds the origin. The user answers every
// query with a reply request (operation 1) whose solid bit tells whether that
// voxel is occupied. A solid reply ends the walk with a hit result (kind 1):
// voxel, travelled distance, entry face normal and hit point. An empty reply
// steps across the nearest voxel boundary and either issues the next query
// or, once the travelled distance passes the maximum, a miss result. A zero
// direction gives a miss at once. A reply while no walk is active is taken
// and dropped; a start while walking abandons the old walk.
// The block takes one request at a time and holds in_stall_o high while it
// works. A start request runs a multiply/accumulate pass per axis for the
// squared length, the zero-length check, one-bit normalize shifts until the
// largest component reaches 2^30, a pass per axis for the scaled squared
// length, a 32-step bit-serial square root, and per axis one pass through
// the shared one-bit-per-cycle divider for the unit component, one for the
// crossing distance and S_NB1 to S_NB3 for the first boundary, the first two
// of them on the shared multiplier. An axis whose unit component comes out
// as zero skips its second division. A zero direction goes from the
// zero-length check straight to its miss. An empty reply runs S_PICK, S_ADV
// and S_LIM; a solid reply runs S_HITM and S_HITA per axis, using the shared
// multiplier for each hit point coordinate.
// A finished result sits in the output register, so the next request can be
// taken while the previous result is still stalled; a new result that finds
// the register still full waits for it, and the block stays busy meanwhile.
module voxel_ray_traversal_top import vrt_pkg::*; #(
  parameter int VOXEL_BITS = vrt_pkg::VOXEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic        [30:0] max_dist_i,
  input  logic               solid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic               hit_o,
  output logic        [30:0] hit_distance_o,
  output logic signed [1:0]  normal_x_o,
  output logic signed [1:0]  normal_y_o,
  output logic signed [1:0]  normal_z_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o
);

  localparam int MUL_W = 33;

  typedef enum logic [4:0] {
    S_IDLE, S_SQM, S_SQA, S_ZCHK, S_NORM, S_SQRT, S_UDIV, S_UWAIT, S_DWAIT,
    S_NB1, S_NB2, S_NB3, S_PICK, S_ADV, S_LIM, S_HITM, S_HITA, S_EMIT
  } state_e;

  typedef enum logic [1:0] {R_QUERY, R_HIT, R_MISS} res_e;

  state_e state_q;
  res_e   rcode_q;

  // Ray state, one entry per axis.
  logic signed [31:0]           origin_q [3];
  logic        [31:0]           mag_q    [3];
  logic                         dneg_q   [3];
  logic signed [U_W:0]          unit_q   [3];
  logic                         step_neg_q [3];
  logic        [T_W-1:0]        dt_q     [3];
  logic        [T_W-1:0]        nb_q     [3];
  logic        [VOXEL_BITS-1:0] cur_q    [3];
  logic signed [1:0]            normal_q [3];
  logic signed [31:0]           point_q  [3];

  logic [T_W-1:0] trav_q;
  logic [30:0]    limit_q;
  logic           walking_q;
  logic           phase_q;
  logic [1:0]     idx_q;
  logic [31:0]    max_q;
  logic [63:0]    acc_q;
  logic [63:0]    root_q;
  logic [62:0]    bit_q;

  logic signed [2*MUL_W-1:0] prod_q;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] prod_d;

  div_req_t div_req_q;
  div_rsp_t div_rsp;

  // Output register.
  logic               out_valid_q;
  logic               kind_q;
  logic signed [15:0] voxel_q [3];
  logic               hit_q;
  logic        [30:0] dist_q;
  logic signed [1:0]  onorm_q [3];
  logic signed [31:0] opoint_q [3];

  logic signed [31:0] in_origin [3];
  logic signed [31:0] in_dir    [3];

  assign in_origin[0] = origin_x_i;
  assign in_origin[1] = origin_y_i;
  assign in_origin[2] = origin_z_i;
  assign in_dir[0]    = dir_x_i;
  assign in_dir[1]    = dir_y_i;
  assign in_dir[2]    = dir_z_i;

  vrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // Fraction of the origin toward the first boundary in the step direction.
  logic [FRAC_BITS-1:0] frac;
  logic [U_W-1:0]       fv;

  assign frac = origin_q[idx_q][FRAC_BITS-1:0];
  assign fv   = step_neg_q[idx_q] ? U_W'(frac) : ONE_Q - U_W'(frac);

  // The one multiplier of the block, its operands chosen by the sequencer.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQM: begin
        mul_a = MUL_W'(mag_q[idx_q]);
        mul_b = MUL_W'(mag_q[idx_q]);
      end
      S_NB1: begin
        mul_a = MUL_W'(fv);
        mul_b = MUL_W'(dt_q[idx_q][T_W-1:FRAC_BITS]);
      end
      S_NB2: begin
        mul_a = MUL_W'(fv);
        mul_b = MUL_W'(dt_q[idx_q][FRAC_BITS-1:0]);
      end
      S_HITM: begin
        mul_a = MUL_W'(unit_q[idx_q]);
        mul_b = MUL_W'(trav_q[31:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Square root step: one result bit per cycle.
  logic [63:0] sq_t;
  logic        sq_ge;

  assign sq_t  = root_q + 64'(bit_q);
  assign sq_ge = acc_q >= sq_t;

  // Largest direction magnitude.
  logic [31:0] m01;
  logic [31:0] mmax;

  assign m01  = (mag_q[1] > mag_q[0]) ? mag_q[1] : mag_q[0];
  assign mmax = (mag_q[2] > m01) ? mag_q[2] : m01;

  // First boundary distance: high partial product plus the shifted low one.
  logic [63:0]    mq_sum;
  logic [T_W-1:0] mq_sat;

  assign mq_sum = acc_q + 64'(prod_q[63:FRAC_BITS]);
  assign mq_sat = (mq_sum > 64'(T_MAX)) ? T_MAX : mq_sum[T_W-1:0];

  // Next boundary on the stepped axis.
  logic [T_W:0]   adv_sum;
  logic [T_W-1:0] adv_sat;

  assign adv_sum = {1'b0, nb_q[idx_q]} + {1'b0, dt_q[idx_q]};
  assign adv_sat = adv_sum[T_W] ? T_MAX : adv_sum[T_W-1:0];

  // Nearest boundary; equal distances go to the later axis.
  logic [1:0] pick_ax;

  always_comb begin
    if (nb_q[0] < nb_q[1]) begin
      pick_ax = (nb_q[0] < nb_q[2]) ? 2'd0 : 2'd2;
    end else begin
      pick_ax = (nb_q[1] < nb_q[2]) ? 2'd1 : 2'd2;
    end
  end

  // Voxel of the origin: floor of the coordinate, wrapped.
  logic signed [63:0]     oext;
  logic [VOXEL_BITS-1:0]  vox_floor;

  assign oext      = 64'(origin_q[idx_q]);
  assign vox_floor = oext[FRAC_BITS+VOXEL_BITS-1:FRAC_BITS];

  // Unit magnitude out of the divider.
  logic [U_W-1:0]      u_mag;
  logic signed [U_W:0] u_ext;

  assign u_mag = div_rsp.quot[U_W-1:0];
  assign u_ext = signed'({1'b0, u_mag});

  logic signed [15:0] vox_out [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vox_out[i] = 16'(signed'(cur_q[i]));
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rcode_q     <= R_QUERY;
      walking_q   <= 1'b0;
      phase_q     <= 1'b0;
      idx_q       <= '0;
      trav_q      <= '0;
      limit_q     <= '0;
      max_q       <= '0;
      acc_q       <= '0;
      root_q      <= '0;
      bit_q       <= '0;
      prod_q      <= '0;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= 1'b0;
      hit_q       <= 1'b0;
      dist_q      <= '0;
      for (int i = 0; i < 3; i++) begin
        origin_q[i]   <= '0;
        mag_q[i]      <= '0;
        dneg_q[i]     <= 1'b0;
        unit_q[i]     <= '0;
        step_neg_q[i] <= 1'b0;
        dt_q[i]       <= '0;
        nb_q[i]       <= '0;
        cur_q[i]      <= '0;
        normal_q[i]   <= '0;
        point_q[i]    <= '0;
        voxel_q[i]    <= '0;
        onorm_q[i]    <= '0;
        opoint_q[i]   <= '0;
      end
    end else begin
      prod_q          <= prod_d;
      div_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (!operation_i) begin
              for (int i = 0; i < 3; i++) begin
                origin_q[i] <= in_origin[i];
                mag_q[i]    <= in_dir[i][31] ? 32'(-in_dir[i]) : 32'(in_dir[i]);
                dneg_q[i]   <= in_dir[i][31];
                normal_q[i] <= '0;
              end
              limit_q <= max_dist_i;
              trav_q  <= '0;
              acc_q   <= '0;
              phase_q <= 1'b0;
              idx_q   <= '0;
              state_q <= S_SQM;
            end else if (walking_q) begin
              idx_q   <= '0;
              state_q <= solid_i ? S_HITM : S_PICK;
            end
          end
        end

        S_SQM: begin
          state_q <= S_SQA;
        end

        S_SQA: begin
          acc_q <= acc_q + prod_q[63:0];
          if (idx_q == 2'd2) begin
            idx_q <= '0;
            if (phase_q) begin
              root_q  <= '0;
              bit_q   <= 63'(64'd1 << 62);
              state_q <= S_SQRT;
            end else begin
              state_q <= S_ZCHK;
            end
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_SQM;
          end
        end

        S_ZCHK: begin
          if (acc_q < LEN_SQ_MIN) begin
            walking_q <= 1'b0;
            rcode_q   <= R_MISS;
            state_q   <= S_EMIT;
          end else begin
            max_q   <= mmax;
            acc_q   <= '0;
            state_q <= S_NORM;
          end
        end

        S_NORM: begin
          // Scale all components together until the largest reaches 2^30.
          if (max_q[31:30] == 2'b00) begin
            max_q <= {max_q[30:0], 1'b0};
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= {mag_q[i][30:0], 1'b0};
            end
          end else begin
            phase_q <= 1'b1;
            idx_q   <= '0;
            state_q <= S_SQM;
          end
        end

        S_SQRT: begin
          if (sq_ge) begin
            acc_q  <= acc_q - sq_t;
            root_q <= (root_q >> 1) + 64'(bit_q);
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            idx_q   <= '0;
            state_q <= S_UDIV;
          end
        end

        S_UDIV: begin
          div_req_q.start <= 1'b1;
          div_req_q.rem   <= REM_W'(mag_q[idx_q] >> 1);
          div_req_q.num   <= {mag_q[idx_q][0], {(NUM_W-1){1'b0}}};
          div_req_q.den   <= root_q[DEN_W-1:0];
          div_req_q.iters <= CNT_W'(FRAC_BITS + 1);
          state_q         <= S_UWAIT;
        end

        S_UWAIT: begin
          if (div_rsp.done) begin
            unit_q[idx_q]     <= dneg_q[idx_q] ? -u_ext : u_ext;
            step_neg_q[idx_q] <= dneg_q[idx_q] && (u_mag != '0);
            if (u_mag > EPS_UNIT) begin
              div_req_q.start <= 1'b1;
              div_req_q.rem   <= '0;
              div_req_q.num   <= {1'b1, {(NUM_W-1){1'b0}}};
              div_req_q.den   <= DEN_W'(u_mag);
              div_req_q.iters <= CNT_W'(NUM_W);
              state_q         <= S_DWAIT;
            end else begin
              dt_q[idx_q] <= T_MAX;
              state_q     <= S_NB1;
            end
          end
        end

        S_DWAIT: begin
          if (div_rsp.done) begin
            dt_q[idx_q] <= T_W'(div_rsp.quot);
            state_q     <= S_NB1;
          end
        end

        S_NB1: begin
          state_q <= S_NB2;
        end

        S_NB2: begin
          acc_q   <= prod_q[63:0];
          state_q <= S_NB3;
        end

        S_NB3: begin
          nb_q[idx_q]  <= mq_sat;
          cur_q[idx_q] <= vox_floor;
          if (idx_q == 2'd2) begin
            walking_q <= 1'b1;
            rcode_q   <= R_QUERY;
            state_q   <= S_EMIT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_UDIV;
          end
        end

        S_PICK: begin
          idx_q   <= pick_ax;
          state_q <= S_ADV;
        end

        S_ADV: begin
          cur_q[idx_q] <= step_neg_q[idx_q] ? cur_q[idx_q] - VOXEL_BITS'(1)
                                            : cur_q[idx_q] + VOXEL_BITS'(1);
          trav_q <= nb_q[idx_q];
          for (int i = 0; i < 3; i++) begin
            normal_q[i] <= '0;
          end
          normal_q[idx_q] <= step_neg_q[idx_q] ? 2'sd1 : -2'sd1;
          nb_q[idx_q]     <= adv_sat;
          state_q         <= S_LIM;
        end

        S_LIM: begin
          if (trav_q <= T_W'(limit_q)) begin
            rcode_q <= R_QUERY;
          end else begin
            walking_q <= 1'b0;
            rcode_q   <= R_MISS;
          end
          state_q <= S_EMIT;
        end

        S_HITM: begin
          state_q <= S_HITA;
        end

        S_HITA: begin
          point_q[idx_q] <= origin_q[idx_q] + prod_q[FRAC_BITS+31:FRAC_BITS];
          if (idx_q == 2'd2) begin
            walking_q <= 1'b0;
            rcode_q   <= R_HIT;
            state_q   <= S_EMIT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_HITM;
          end
        end

        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            kind_q      <= (rcode_q != R_QUERY);
            hit_q       <= (rcode_q == R_HIT);
            dist_q      <= (rcode_q == R_HIT) ? trav_q[30:0] : '0;
            for (int i = 0; i < 3; i++) begin
              voxel_q[i]  <= (rcode_q == R_MISS) ? '0 : vox_out[i];
              onorm_q[i]  <= (rcode_q == R_QUERY) ? '0 : normal_q[i];
              opoint_q[i] <= (rcode_q == R_HIT) ? point_q[i] : '0;
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign voxel_x_o      = voxel_q[0];
  assign voxel_y_o      = voxel_q[1];
  assign voxel_z_o      = voxel_q[2];
  assign hit_o          = hit_q;
  assign hit_distance_o = dist_q;
  assign normal_x_o     = onorm_q[0];
  assign normal_y_o     = onorm_q[1];
  assign normal_z_o     = onorm_q[2];
  assign point_x_o      = opoint_q[0];
  assign point_y_o      = opoint_q[1];
  assign point_z_o      = opoint_q[2];

endmodule

[design/vrt_div.sv]
module vrt_div import vrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // One quotient bit per cycle. The caller preloads the partial remainder
  // and left-aligns the numerator bits still to be brought down.
  logic [REM_W-1:0] rem_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [QUO_W-1:0] quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [REM_W-1:0] rem_sh;
  logic             ge;
  logic [REM_W-1:0] rem_nx;

  assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= req_i.rem;
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        cnt_q  <= req_i.iters;
        quot_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= rem_nx;
        num_q  <= {num_q[NUM_W-2:0], 1'b0};
        quot_q <= {quot_q[QUO_W-2:0], ge};
        cnt_q  <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, quot: quot_q};

endmodule

[design/vrt_chk.sv]
module vrt_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               operation_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               kind_o,
  input logic signed [15:0] voxel_x_o,
  input logic signed [15:0] voxel_y_o,
  input logic signed [15:0] voxel_z_o,
  input logic               hit_o,
  input logic        [30:0] hit_distance_o,
  input logic signed [1:0]  normal_x_o,
  input logic signed [1:0]  normal_y_o,
  input logic signed [1:0]  normal_z_o,
  input logic signed [31:0] point_x_o,
  input logic signed [31:0] point_y_o,
  input logic signed [31:0] point_z_o
);

  // A result request stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // A start request always keeps the block busy for the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !operation_i |=> in_stall_o)
    else $error("block free right after a start request");

  // A voxel query carries only the voxel.
  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> !hit_o && hit_distance_o == 31'd0 &&
      normal_x_o == 2'sd0 && normal_y_o == 2'sd0 && normal_z_o == 2'sd0 &&
      point_x_o == 32'sd0 && point_y_o == 32'sd0 && point_z_o == 32'sd0)
    else $error("query result carries hit fields");

  // A miss reports no voxel, no distance and no point.
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && !hit_o |->
      voxel_x_o == 16'sd0 && voxel_y_o == 16'sd0 && voxel_z_o == 16'sd0 &&
      hit_distance_o == 31'd0 &&
      point_x_o == 32'sd0 && point_y_o == 32'sd0 && point_z_o == 32'sd0)
    else $error("miss result carries hit fields");

  // The entry face lies on one axis at most.
  a_one_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({normal_x_o != 2'sd0, normal_y_o != 2'sd0,
                                normal_z_o != 2'sd0}) <= 1)
    else $error("face normal on more than one axis");

endmodule

bind voxel_ray_traversal_top vrt_chk u_vrt_chk (.*);
